// ===== hdl/tkst_pkg.sv =====
// tkst_pkg: request/response types, opcodes and controller states for the
// top-K sorted insert table. No dependencies.
package tkst_pkg;

  // Opcode values carried in the request
  localparam logic OP_SUBMIT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Width of rank, position and fill-count values
  localparam int RANK_W = 4;

  // One request
  typedef struct packed {
    logic               opcode;
    logic [2:0]         category;
    logic signed [31:0] score;
    logic [15:0]        owner_tag;
    logic [31:0]        stamp;
    logic [RANK_W-1:0]  rank_index;
  } req_t;

  // One response
  typedef struct packed {
    logic               placed;
    logic [RANK_W-1:0]  place_rank;
    logic               entry_valid;
    logic signed [31:0] entry_score;
    logic [15:0]        entry_owner;
    logic [31:0]        entry_stamp;
  } rsp_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_INSERT
  } state_t;

endpackage

// ===== hdl/top_k_sorted_insert_table.sv =====
// top_k_sorted_insert_table: per-category top-K lists held in one entry RAM.
// Depends on tkst_pkg.
//
//   channel   ports                  handshake
//   --------  ---------------------  ----------------------------------------
//   request   req (tkst_pkg::req_t)  taken on a clock edge with start & !busy
//   response  rsp (tkst_pkg::rsp_t)  valid for the single cycle done is high
//
// Each request gives one response. A read of a valid rank responds from ST_READ,
// after the registered RAM read; other reads and bad categories respond straight
// from ST_IDLE. A submit walks the list bottom-up through the entry RAM and its
// registered read port, shifting one entry per cycle, then writes the new entry
// in ST_INSERT; an empty list goes straight to ST_INSERT, and a full list with
// every entry at or above the new score drops the request from ST_SCAN.
// Synchronous reset empties all lists; RAM contents are not cleared. The
// receiver cannot stall: a new request may be taken in the cycle the previous
// response is shown.
module top_k_sorted_insert_table #(
  parameter int DEPTH      = 10,
  parameter int CATEGORIES = 8,
  parameter int TAG_BITS   = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  tkst_pkg::req_t  req,
  output logic            done,
  output tkst_pkg::rsp_t  rsp
);

  localparam int SLOTS   = CATEGORIES * DEPTH;
  localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CAT_W   = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;
  localparam int OWN_W   = (TAG_BITS < 16) ? TAG_BITS : 16;
  localparam int ENTRY_W = 32 + OWN_W + 32;
  localparam int RW      = tkst_pkg::RANK_W;

  tkst_pkg::state_t state, state_next;

  tkst_pkg::req_t  req_q;
  logic [ADDR_W-1:0] base_q;
  logic [CAT_W-1:0]  cat_q;
  logic [RW-1:0]     cnt_q;
  logic [RW-1:0]     wpos, wpos_next;
  logic [RW-1:0]     fill_count [CATEGORIES];

  logic [ENTRY_W-1:0] mem [SLOTS];
  logic [ENTRY_W-1:0] rd_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               fill_wr;

  logic               done_next;
  tkst_pkg::rsp_t     rsp_next;

  logic               accept;
  logic [CAT_W-1:0]   in_cat;
  logic               in_cat_ok;
  logic [ADDR_W-1:0]  in_base;
  logic [RW-1:0]      in_cnt;
  logic signed [31:0] rd_score;
  logic [ENTRY_W-1:0] new_entry;
  logic               ge;

  assign busy    = (state != tkst_pkg::ST_IDLE);
  assign accept  = start & ~busy;

  // Decode of the incoming request
  assign in_cat    = req.category[CAT_W-1:0];
  assign in_cat_ok = ({1'b0, req.category} < 4'(CATEGORIES));
  assign in_base   = ADDR_W'(in_cat) * ADDR_W'(DEPTH);
  assign in_cnt    = in_cat_ok ? fill_count[in_cat] : '0;

  // Entry layout: score | owner | stamp
  assign rd_score  = $signed(rd_data[ENTRY_W-1 -: 32]);
  assign new_entry = {req_q.score, req_q.owner_tag[OWN_W-1:0], req_q.stamp};
  // Stored entry at or above the new score: new entry goes just below it
  assign ge        = (rd_score >= req_q.score);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tkst_pkg::ST_IDLE: begin
        if (accept && in_cat_ok) begin
          if (req.opcode == tkst_pkg::OP_READ) begin
            if (req.rank_index < in_cnt) state_next = tkst_pkg::ST_READ;
          end else if (in_cnt == '0) begin
            state_next = tkst_pkg::ST_INSERT;
          end else begin
            state_next = tkst_pkg::ST_SCAN;
          end
        end
      end
      tkst_pkg::ST_READ: state_next = tkst_pkg::ST_IDLE;
      tkst_pkg::ST_SCAN: begin
        if (ge) begin
          state_next = (wpos < RW'(DEPTH)) ? tkst_pkg::ST_INSERT : tkst_pkg::ST_IDLE;
        end else if (wpos == RW'(1)) begin
          state_next = tkst_pkg::ST_INSERT;
        end
      end
      tkst_pkg::ST_INSERT: state_next = tkst_pkg::ST_IDLE;
      default: state_next = tkst_pkg::ST_IDLE;
    endcase
  end

  // RAM controls, scan position and response
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = rd_data;
    fill_wr   = 1'b0;
    wpos_next = wpos;
    done_next = 1'b0;
    rsp_next  = '0;
    case (state)
      tkst_pkg::ST_IDLE: begin
        if (accept) begin
          wpos_next = in_cnt;
          if (!in_cat_ok) begin
            done_next = 1'b1;
          end else if (req.opcode == tkst_pkg::OP_READ) begin
            if (req.rank_index < in_cnt) begin
              rd_en   = 1'b1;
              rd_addr = in_base + ADDR_W'(req.rank_index);
            end else begin
              done_next = 1'b1;
            end
          end else if (in_cnt != '0) begin
            // start the walk at the lowest stored entry
            rd_en   = 1'b1;
            rd_addr = in_base + ADDR_W'(in_cnt - RW'(1));
          end
        end
      end
      tkst_pkg::ST_READ: begin
        done_next            = 1'b1;
        rsp_next.entry_valid = 1'b1;
        rsp_next.entry_score = rd_score;
        rsp_next.entry_owner = 16'(rd_data[32 +: OWN_W]);
        rsp_next.entry_stamp = rd_data[31:0];
      end
      tkst_pkg::ST_SCAN: begin
        if (ge) begin
          // full list with every entry at or above: request dropped
          if (wpos >= RW'(DEPTH)) done_next = 1'b1;
        end else begin
          // move the entry one rank down; the bottom one falls off a full list
          if (wpos < RW'(DEPTH)) begin
            wr_en   = 1'b1;
            wr_addr = base_q + ADDR_W'(wpos);
          end
          wpos_next = wpos - RW'(1);
          if (wpos != RW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = base_q + ADDR_W'(wpos - RW'(2));
          end
        end
      end
      tkst_pkg::ST_INSERT: begin
        wr_en               = 1'b1;
        wr_addr             = base_q + ADDR_W'(wpos);
        wr_data             = new_entry;
        fill_wr             = 1'b1;
        done_next           = 1'b1;
        rsp_next.placed     = 1'b1;
        rsp_next.place_rank = wpos;
      end
      default: ;
    endcase
  end

  // Entry RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Request capture and scan position
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= req;
      base_q <= in_base;
      cat_q  <= in_cat;
      cnt_q  <= in_cnt;
    end
    wpos <= wpos_next;
    rsp  <= rsp_next;
  end

  // Control state and per-category fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tkst_pkg::ST_IDLE;
      done  <= 1'b0;
      for (int c = 0; c < CATEGORIES; c++) fill_count[c] <= '0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (fill_wr && (cnt_q < RW'(DEPTH))) fill_count[cat_q] <= cnt_q + RW'(1);
    end
  end

endmodule

// ===== tb/sv/top_k_sorted_insert_table_tb.sv =====
// top_k_sorted_insert_table_tb: drives submit/read requests into the top-K table and
// checks each response against local lists or a pinned answer. Depends on tkst_pkg.
`timescale 1ns / 1ps

module top_k_sorted_insert_table_tb;

  localparam int DEPTH       = 10;
  localparam int CATEGORIES  = 8;
  localparam int TAG_BITS    = 16;
  localparam int RANK_W      = tkst_pkg::RANK_W;
  localparam logic [15:0] TAG_MASK = 16'((33'h1 << TAG_BITS) - 1);
  localparam int MAX_GAP     = 20;
  localparam int PHASE_ITEMS = 234;
  localparam int CYCLE_LIMIT = 200000;

  // One directed request, with its answer typed in when pinned is set
  typedef struct {
    tkst_pkg::req_t rq;
    logic pinned;
    tkst_pkg::rsp_t answer;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic done;
  tkst_pkg::req_t req;
  tkst_pkg::rsp_t rsp;

  // Pinned answer travels beside the request it belongs to
  logic pin_use;
  tkst_pkg::rsp_t pin_rsp;

  // Local copy of the ranked lists
  logic signed [31:0] board_score [CATEGORIES][DEPTH];
  logic [15:0]        board_owner [CATEGORIES][DEPTH];
  logic [31:0]        board_stamp [CATEGORIES][DEPTH];
  int                 board_fill  [CATEGORIES];

  tkst_pkg::rsp_t answer_q[$];
  int   mismatches = 0;
  int   cycle_count = 0;

  top_k_sorted_insert_table #(
    .DEPTH(DEPTH),
    .CATEGORIES(CATEGORIES),
    .TAG_BITS(TAG_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .rsp(rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one request to the local lists and return the response it must give
  function automatic tkst_pkg::rsp_t leaderboard_step(tkst_pkg::req_t r);
    tkst_pkg::rsp_t a;
    int   c;
    int   cnt;
    int   pos;
    a = '0;
    c = int'(r.category);
    if (c >= CATEGORIES) return a;
    cnt = board_fill[c];
    if (r.opcode == tkst_pkg::OP_SUBMIT) begin
      pos = 0;
      while (pos < cnt && board_score[c][pos] >= r.score) pos++;
      if (pos >= DEPTH) return a;
      if (cnt < DEPTH) cnt++;
      for (int i = cnt - 1; i > pos; i--) begin
        board_score[c][i] = board_score[c][i-1];
        board_owner[c][i] = board_owner[c][i-1];
        board_stamp[c][i] = board_stamp[c][i-1];
      end
      board_score[c][pos] = r.score;
      board_owner[c][pos] = r.owner_tag & TAG_MASK;
      board_stamp[c][pos] = r.stamp;
      board_fill[c] = cnt;
      a.placed = 1'b1;
      a.place_rank = RANK_W'(pos);
    end else if (int'(r.rank_index) < cnt) begin
      a.entry_valid = 1'b1;
      a.entry_score = board_score[c][r.rank_index];
      a.entry_owner = board_owner[c][r.rank_index];
      a.entry_stamp = board_stamp[c][r.rank_index];
    end
    return a;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at cycle %0d", field, got, want,
             cycle_count);
    mismatches++;
  endtask

  // Directed rows; unused fields of each kind carry junk on purpose
  function automatic dir_row_t submit_row(logic [2:0] cat, logic signed [31:0] score,
                                          logic [15:0] tag, logic [31:0] stamp,
                                          logic pinned, logic placed, logic [3:0] rank);
    dir_row_t d;
    d.rq = '{opcode: tkst_pkg::OP_SUBMIT, category: cat, score: score, owner_tag: tag,
             stamp: stamp, rank_index: 4'hA};
    d.pinned = pinned;
    d.answer = '0;
    d.answer.placed = placed;
    d.answer.place_rank = rank;
    return d;
  endfunction

  function automatic dir_row_t read_row(logic [2:0] cat, logic [3:0] rank, logic pinned,
                                        logic valid, logic signed [31:0] score,
                                        logic [15:0] owner, logic [31:0] stamp);
    dir_row_t d;
    d.rq = '{opcode: tkst_pkg::OP_READ, category: cat, score: -32'sd1,
             owner_tag: 16'hFFFF, stamp: 32'hFFFF_FFFF, rank_index: rank};
    d.pinned = pinned;
    d.answer = '{placed: 1'b0, place_rank: '0, entry_valid: valid, entry_score: score,
                 entry_owner: owner, entry_stamp: stamp};
    return d;
  endfunction

  // Random request: ties, extremes and a few busy categories so lists fill up
  function automatic tkst_pkg::req_t random_request();
    tkst_pkg::req_t r;
    r.opcode = ($urandom_range(99) < 55) ? tkst_pkg::OP_SUBMIT : tkst_pkg::OP_READ;
    r.category = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(2));
    case ($urandom_range(3))
      0: r.score = $urandom;
      1: r.score = 32'($urandom_range(16)) - 32'd8;
      2: begin
        case ($urandom_range(3))
          0: r.score = 32'h7FFF_FFFF;
          1: r.score = 32'h8000_0000;
          2: r.score = 32'h0;
          default: r.score = 32'hFFFF_FFFF;
        endcase
      end
      default: r.score = 32'($urandom_range(2000)) - 32'd1000;
    endcase
    r.owner_tag = 16'($urandom);
    r.stamp = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF : $urandom;
    r.rank_index = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
    return r;
  endfunction

  // Idle for a random gap, then hold the request until it is taken
  task automatic send_request(tkst_pkg::req_t r, logic pinned, tkst_pkg::rsp_t answer,
                              int idle_pct);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    pin_use <= pinned;
    pin_rsp <= answer;
    do @(posedge clk); while (busy);
  endtask

  // Stop sending and wait for every outstanding response
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  // Response check, then prediction for a request taken at this edge
  always @(posedge clk) begin
    tkst_pkg::rsp_t want;
    tkst_pkg::rsp_t predicted;
    if (!rst) begin
      if (done) begin
        if (answer_q.size() == 0) begin
          report_mismatch("unexpected response", 64'(rsp), '0);
        end else begin
          want = answer_q.pop_front();
          if (rsp.placed !== want.placed)
            report_mismatch("placed", 64'(rsp.placed), 64'(want.placed));
          if (rsp.place_rank !== want.place_rank)
            report_mismatch("place_rank", 64'(rsp.place_rank), 64'(want.place_rank));
          if (rsp.entry_valid !== want.entry_valid)
            report_mismatch("entry_valid", 64'(rsp.entry_valid), 64'(want.entry_valid));
          if (rsp.entry_score !== want.entry_score)
            report_mismatch("entry_score", 64'(rsp.entry_score), 64'(want.entry_score));
          if (rsp.entry_owner !== want.entry_owner)
            report_mismatch("entry_owner", 64'(rsp.entry_owner), 64'(want.entry_owner));
          if (rsp.entry_stamp !== want.entry_stamp)
            report_mismatch("entry_stamp", 64'(rsp.entry_stamp), 64'(want.entry_stamp));
        end
      end
      if (start && !busy) begin
        predicted = leaderboard_step(req);
        answer_q.push_back(pin_use ? pin_rsp : predicted);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("top_k_sorted_insert_table_tb failed");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    int       idle_pct;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    pin_use = 1'b0;
    pin_rsp = '0;
    foreach (board_fill[c]) board_fill[c] = 0;

    // Directed: empty read, extremes, ties, out-of-range reads, full list
    rows.push_back(read_row(0, 0, 1, 0, 0, 0, 0));
    rows.push_back(submit_row(0, 32'sh7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1, 1, 0));
    rows.push_back(submit_row(0, 32'sh8000_0000, 16'h0000, 32'h0, 1, 1, 1));
    rows.push_back(submit_row(0, 32'sd0, 16'h1234, 32'h5, 1, 1, 1));
    rows.push_back(submit_row(0, 32'sd0, 16'h1235, 32'h6, 1, 1, 2));
    rows.push_back(read_row(0, 0, 1, 1, 32'sh7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    rows.push_back(read_row(0, 3, 1, 1, 32'sh8000_0000, 16'h0000, 32'h0));
    rows.push_back(read_row(0, 1, 0, 0, 0, 0, 0));
    rows.push_back(read_row(0, 4, 1, 0, 0, 0, 0));
    rows.push_back(read_row(0, 15, 1, 0, 0, 0, 0));
    for (int k = 0; k < DEPTH; k++)
      rows.push_back(submit_row(7, 32'sh8000_0000, 16'h0100 + 16'(k), 32'(k), 0, 0, 0));
    // list full and every score ties the new one: entry is dropped
    rows.push_back(submit_row(7, 32'sh8000_0000, 16'hBEEF, 32'd99, 1, 0, 0));
    // new top entry pushes the lowest off the end
    rows.push_back(submit_row(7, -32'sd1, 16'hCAFE, 32'd100, 0, 0, 0));
    rows.push_back(read_row(7, 9, 0, 0, 0, 0, 0));
    rows.push_back(read_row(7, 0, 0, 0, 0, 0, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_request(rows[i].rq, rows[i].pinned, rows[i].answer, 30);
    wait_drained();

    // Random phases: light sender idling, heavy idling, then back to back
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 6 : (phase == 1) ? 55 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_request(), 0, '0, idle_pct);
      wait_drained();
    end

    repeat (DEPTH + 4) @(posedge clk);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("top_k_sorted_insert_table_tb passed");
    end else begin
      $display("top_k_sorted_insert_table_tb failed");
    end
    $finish;
  end

endmodule

// ===== top_k_sorted_insert_table.f =====
hdl/tkst_pkg.sv
hdl/top_k_sorted_insert_table.sv
tb/sv/top_k_sorted_insert_table_tb.sv
